// ----- rtl/msshuf_pkg.sv -----
// Package for the masked share shuffle block.
// Holds sizes, item structs, command and status structs, and the controller state type.
package msshuf_pkg;

  localparam int MAX_N  = 64;
  localparam int DATA_W = 64;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;

  // One loaded element
  typedef struct packed {
    logic [DATA_W-1:0] first_share;
    logic [DATA_W-1:0] second_share;
    logic [DATA_W-1:0] mask_a0;
    logic [DATA_W-1:0] mask_a1;
    logic [DATA_W-1:0] mask_b0;
    logic [DATA_W-1:0] mask_b1;
    logic [IDX_W-1:0]  inner_perm_entry;
    logic [IDX_W-1:0]  outer_perm_entry;
    logic              last_in;
  } in_item_t;

  // One result element
  typedef struct packed {
    logic [DATA_W-1:0] out_share0;
    logic [DATA_W-1:0] out_share1;
    logic              last_out;
    logic              perm_error;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             inner_issue;
    logic             outer_issue;
    logic             run_done;
    logic [IDX_W-1:0] idx;
  } msshuf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CNT_W-1:0] count;
  } msshuf_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INNER,
    ST_INNER_WAIT,
    ST_OUTER,
    ST_OUTER_WAIT
  } msshuf_state_t;

endpackage

// ----- rtl/msshuf_ctrl.sv -----
// Controller for the masked share shuffle: load, inner pass, outer pass.
// Depends on msshuf_pkg for the state type and command/status structs.
module msshuf_ctrl import msshuf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        last_in,
  input  msshuf_sts_t sts,
  output logic        busy,
  output msshuf_cmd_t cmd
);

  msshuf_state_t    state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             wait_r, wait_nxt;
  logic             idx_end;

  // Last loaded index reached
  assign idx_end = ({1'b0, idx_r} == (sts.count - CNT_W'(1)));

  // Next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    wait_nxt  = wait_r;
    case (state_r)
      ST_IDLE: begin
        idx_nxt  = '0;
        wait_nxt = 1'b0;
        if (start && last_in) begin
          state_nxt = ST_INNER;
        end
      end
      ST_INNER: begin
        if (idx_end) begin
          idx_nxt   = '0;
          state_nxt = ST_INNER_WAIT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_INNER_WAIT: begin
        state_nxt = ST_OUTER;
      end
      ST_OUTER: begin
        if (idx_end) begin
          wait_nxt  = 1'b0;
          state_nxt = ST_OUTER_WAIT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_OUTER_WAIT: begin
        wait_nxt = 1'b1;
        if (wait_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.idx  = idx_r;
    busy     = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_INNER: begin
        cmd.inner_issue = 1'b1;
      end
      ST_INNER_WAIT: begin
      end
      ST_OUTER: begin
        cmd.outer_issue = 1'b1;
      end
      ST_OUTER_WAIT: begin
        cmd.run_done = wait_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      wait_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      wait_r  <= wait_nxt;
    end
  end

endmodule

// ----- rtl/msshuf_dpath.sv -----
// Datapath for the masked share shuffle: element stores, gather pipeline,
// error flag and result register. Depends on msshuf_pkg.
module msshuf_dpath import msshuf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  msshuf_cmd_t cmd,
  input  in_item_t    in_data,
  output msshuf_sts_t sts,
  output logic        out_valid,
  output out_item_t   out_data
);

  // Element stores
  logic [DATA_W-1:0] summed_mem [MAX_N];
  logic [DATA_W-1:0] a1_mem     [MAX_N];
  logic [DATA_W-1:0] b0_mem     [MAX_N];
  logic [DATA_W-1:0] b1_mem     [MAX_N];
  logic [IDX_W-1:0]  inner_mem  [MAX_N];
  logic [IDX_W-1:0]  outer_mem  [MAX_N];
  logic [DATA_W-1:0] middle_mem [MAX_N];

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              err_r, err_nxt;
  logic              load_ok;

  // Stage A: per-index reads
  logic [IDX_W-1:0]  rd_inner_r, rd_outer_r;
  logic [DATA_W-1:0] rd_a1_r, rd_b0_r, rd_b1_r;
  logic              sa_inner_v_r, sa_outer_v_r;
  logic [IDX_W-1:0]  sa_idx_r;

  // Stage B: gathered reads
  logic [DATA_W-1:0] sum_q_r, mid_q_r;
  logic [DATA_W-1:0] a1_b_r, b0_b_r, b1_b_r;
  logic              src_ok_r, src_ok_nxt;
  logic              sb_inner_v_r, sb_outer_v_r;
  logic [IDX_W-1:0]  sb_idx_r;
  logic              inner_ok, outer_ok;

  logic [DATA_W-1:0] mid_val, out_sel;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r;

  assign load_ok  = cmd.load && (cnt_r < CNT_W'(MAX_N));
  assign sts.count = cnt_r;

  // Load count: advance on a stored element, clear when the run ends
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.run_done) begin
      cnt_nxt = '0;
    end else if (load_ok) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // Range checks against the loaded count
  assign inner_ok = ({1'b0, rd_inner_r} < cnt_r);
  assign outer_ok = ({1'b0, rd_outer_r} < cnt_r);
  assign src_ok_nxt = sa_inner_v_r ? inner_ok : outer_ok;

  // Both entries are checked in the inner pass so the flag is whole before output
  always_comb begin
    err_nxt = err_r;
    if (cmd.run_done) begin
      err_nxt = 1'b0;
    end else if (sa_inner_v_r && !(inner_ok && outer_ok)) begin
      err_nxt = 1'b1;
    end
  end

  // Load writes
  always_ff @(posedge clk) begin
    if (load_ok) begin
      summed_mem[cnt_r[IDX_W-1:0]] <= in_data.first_share + in_data.mask_a0
                                      + in_data.second_share;
      a1_mem[cnt_r[IDX_W-1:0]]    <= in_data.mask_a1;
      b0_mem[cnt_r[IDX_W-1:0]]    <= in_data.mask_b0;
      b1_mem[cnt_r[IDX_W-1:0]]    <= in_data.mask_b1;
      inner_mem[cnt_r[IDX_W-1:0]] <= in_data.inner_perm_entry;
      outer_mem[cnt_r[IDX_W-1:0]] <= in_data.outer_perm_entry;
    end
  end

  // Stage A reads
  always_ff @(posedge clk) begin
    rd_inner_r <= inner_mem[cmd.idx];
    rd_outer_r <= outer_mem[cmd.idx];
    rd_a1_r    <= a1_mem[cmd.idx];
    rd_b0_r    <= b0_mem[cmd.idx];
    rd_b1_r    <= b1_mem[cmd.idx];
    sa_idx_r   <= cmd.idx;
  end

  // Stage B gather reads
  always_ff @(posedge clk) begin
    sum_q_r  <= summed_mem[rd_inner_r];
    mid_q_r  <= middle_mem[rd_outer_r];
    a1_b_r   <= rd_a1_r;
    b0_b_r   <= rd_b0_r;
    b1_b_r   <= rd_b1_r;
    src_ok_r <= src_ok_nxt;
    sb_idx_r <= sa_idx_r;
  end

  // Inner pass result goes to the middle store
  assign mid_val = (src_ok_r ? sum_q_r : '0) + a1_b_r;

  always_ff @(posedge clk) begin
    if (sb_inner_v_r) begin
      middle_mem[sb_idx_r] <= mid_val;
    end
  end

  // Outer pass result
  assign out_sel = src_ok_r ? mid_q_r : '0;

  always_comb begin
    out_nxt.out_share0 = out_sel - b0_b_r;
    out_nxt.out_share1 = '0 - b1_b_r;
    out_nxt.last_out   = ({1'b0, sb_idx_r} == (cnt_r - CNT_W'(1)));
    out_nxt.perm_error = err_r;
  end

  always_ff @(posedge clk) begin
    if (sb_outer_v_r) begin
      out_r <= out_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      err_r        <= 1'b0;
      sa_inner_v_r <= 1'b0;
      sa_outer_v_r <= 1'b0;
      sb_inner_v_r <= 1'b0;
      sb_outer_v_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      err_r        <= err_nxt;
      sa_inner_v_r <= cmd.inner_issue;
      sa_outer_v_r <= cmd.outer_issue;
      sb_inner_v_r <= sa_inner_v_r;
      sb_outer_v_r <= sa_outer_v_r;
      out_valid_r  <= sb_outer_v_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/masked_share_shuffle_top.sv -----
// Masked share shuffle, top level: ties controller and datapath together.
// Loads one item per cycle while not busy; the item with last_in starts two gather passes.
// Results: after the last item, an inner and then an outer pass run; results come one per cycle.
// No item is taken while busy; the next vector loads once the run ends and the block is idle.
// Passes are one index per cycle, bounded by the single read port per store.
// Reset (synchronous, rst_n low) clears load count, error flag and control.
module masked_share_shuffle_top import msshuf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  msshuf_cmd_t cmd;
  msshuf_sts_t sts;

  // Sequencer
  msshuf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .last_in (in_data.last_in),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  // Stores and gather pipeline
  msshuf_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // Results come during a run; only the final one lands after the block goes idle
  a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !busy) |-> out_data.last_out) else $error("result outside a run");

  // An item without last leaves the block ready
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_data.last_in) |=> !busy) else $error("load left block busy");

  // Final result of a run is not followed by another
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_out) |=> !out_valid) else $error("result after last");
`endif

endmodule

// ----- sim/masked_share_shuffle_top_test.sv -----
// Self-checking bench for masked_share_shuffle_top: loads vectors over the start/busy
// port and checks each shuffled result against a scoreboard that predicts both gathers.
// Depends on msshuf_pkg and the masked_share_shuffle_top RTL.
module masked_share_shuffle_top_test;
  import msshuf_pkg::*;

  localparam int CYCLE_LIMIT = 100000;

  // Predicts the shuffled shares of each vector and keeps them in order of output
  class shuffle_scoreboard;
    logic [DATA_W-1:0] summed    [MAX_N];
    logic [DATA_W-1:0] post_mask [MAX_N];
    logic [DATA_W-1:0] out_mask0 [MAX_N];
    logic [DATA_W-1:0] out_mask1 [MAX_N];
    logic [IDX_W-1:0]  inner_src [MAX_N];
    logic [IDX_W-1:0]  outer_src [MAX_N];
    int                loaded;
    out_item_t         shuffled_q[$];
    int                failures;
    int                checked;
    int                runs;
    int                flagged_runs;

    function new();
      loaded = 0;
      failures = 0;
      checked = 0;
      runs = 0;
      flagged_runs = 0;
    endfunction

    // Note one accepted item; the item marked last queues the whole run
    function void take_element(in_item_t it);
      logic [DATA_W-1:0] gathered [MAX_N];
      logic [DATA_W-1:0] v;
      out_item_t         r;
      bit                bad;
      int                n;
      // elements past MAX_N are dropped, but their last flag still counts
      if (loaded < MAX_N) begin
        summed[loaded]    = it.first_share + it.mask_a0 + it.second_share;
        post_mask[loaded] = it.mask_a1;
        out_mask0[loaded] = it.mask_b0;
        out_mask1[loaded] = it.mask_b1;
        inner_src[loaded] = it.inner_perm_entry;
        outer_src[loaded] = it.outer_perm_entry;
        loaded++;
      end
      if (!it.last_in) return;
      n = loaded;
      // error flag covers every result of the run, so find it first
      bad = 0;
      for (int i = 0; i < n; i++) begin
        if (inner_src[i] >= n || outer_src[i] >= n) bad = 1;
      end
      // inner gather plus a1; an out-of-range entry reads zero
      for (int i = 0; i < n; i++) begin
        v = (inner_src[i] < n) ? summed[inner_src[i]] : '0;
        gathered[i] = v + post_mask[i];
      end
      // outer gather minus b0, party one gets -b1
      for (int i = 0; i < n; i++) begin
        v = (outer_src[i] < n) ? gathered[outer_src[i]] : '0;
        r.out_share0 = v - out_mask0[i];
        r.out_share1 = '0 - out_mask1[i];
        r.last_out   = (i == n - 1);
        r.perm_error = bad;
        shuffled_q.push_back(r);
      end
      runs++;
      if (bad) flagged_runs++;
      loaded = 0;
    endfunction

    // Compare one result with the oldest prediction
    function void compare_result(out_item_t got);
      out_item_t want;
      if (shuffled_q.size() == 0) begin
        $error("unexpected result: out_share0 %h out_share1 %h", got.out_share0,
               got.out_share1);
        failures++;
        return;
      end
      want = shuffled_q.pop_front();
      checked++;
      if (got.out_share0 !== want.out_share0) begin
        $error("out_share0: expected %h, got %h", want.out_share0, got.out_share0);
        failures++;
      end
      if (got.out_share1 !== want.out_share1) begin
        $error("out_share1: expected %h, got %h", want.out_share1, got.out_share1);
        failures++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %b, got %b", want.last_out, got.last_out);
        failures++;
      end
      if (got.perm_error !== want.perm_error) begin
        $error("perm_error: expected %b, got %b", want.perm_error, got.perm_error);
        failures++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  shuffle_scoreboard sb;
  bit                gaps_on;
  int                sent = 0;
  int                cycle_count = 0;

  masked_share_shuffle_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Results cannot be held off; take every strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.compare_result(out_data);
  end

  // Hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("masked_share_shuffle_top: mismatch");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_elem(in_item_t it);
    while (gaps_on && $urandom_range(0, 99) < 13) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    sb.take_element(it);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(DATA_W-1){1'b0}}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_item_t elem(logic [DATA_W-1:0] f, s, a0, a1, b0, b1,
                                    logic [IDX_W-1:0] ip, op, logic last);
    in_item_t it;
    it.first_share      = f;
    it.second_share     = s;
    it.mask_a0          = a0;
    it.mask_a1          = a1;
    it.mask_b0          = b0;
    it.mask_b1          = b1;
    it.inner_perm_entry = ip;
    it.outer_perm_entry = op;
    it.last_in          = last;
    return it;
  endfunction

  // One vector of len items with random content; bad_pct sets how often an
  // entry is drawn over the whole index range instead of the loaded range
  task automatic send_run(int len, int bad_pct);
    int       span;
    in_item_t it;
    span = (len > MAX_N) ? MAX_N : len;
    for (int k = 0; k < len; k++) begin
      it.first_share  = rand_word();
      it.second_share = rand_word();
      it.mask_a0      = rand_word();
      it.mask_a1      = rand_word();
      it.mask_b0      = rand_word();
      it.mask_b1      = rand_word();
      it.inner_perm_entry = ($urandom_range(0, 99) < bad_pct) ?
                            IDX_W'($urandom_range(0, MAX_N - 1)) :
                            IDX_W'($urandom_range(0, span - 1));
      it.outer_perm_entry = ($urandom_range(0, 99) < bad_pct) ?
                            IDX_W'($urandom_range(0, MAX_N - 1)) :
                            IDX_W'($urandom_range(0, span - 1));
      it.last_in = (k == len - 1);
      send_elem(it);
    end
  endtask

  initial begin
    int guard;
    sb      = new();
    start   = 1'b0;
    in_data = '0;
    rst_n   = 1'b0;
    gaps_on = 1'b1;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single element, all ones in every share and mask, both entries zero
    send_elem(elem('1, '1, '1, '1, '1, '1, 6'd0, 6'd0, 1'b1));
    // single element, both entries far out of range
    send_elem(elem('0, '0, '0, '0, '0, '0, 6'd63, 6'd63, 1'b1));
    // reversal over three elements, mixed extremes
    send_elem(elem('0, '1, 64'd1, '0, '1, 64'd1, 6'd2, 6'd2, 1'b0));
    send_elem(elem('1, '1, '1, 64'h8000_0000_0000_0000, '0, '0, 6'd1, 6'd1, 1'b0));
    send_elem(elem(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '0, '1, '1, '1,
                   6'd0, 6'd0, 1'b1));
    // repeated entries, one outer entry just at the loaded count
    send_elem(elem(64'd10, 64'd20, 64'd30, 64'd1, 64'd2, 64'd3, 6'd0, 6'd0, 1'b0));
    send_elem(elem(64'd11, 64'd21, 64'd31, 64'd4, 64'd5, 64'd6, 6'd0, 6'd4, 1'b0));
    send_elem(elem(64'd12, 64'd22, 64'd32, 64'd7, 64'd8, 64'd9, 6'd0, 6'd0, 1'b0));
    send_elem(elem(64'd13, 64'd23, 64'd33, '1, '1, '1, 6'd0, 6'd3, 1'b1));
    // inner entry just at the loaded count, outer in range
    send_elem(elem(64'hdead_beef, 64'h1234, '1, 64'd5, '0, '1, 6'd2, 6'd1, 1'b0));
    send_elem(elem(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, '0, '0, '1, '0,
                   6'd1, 6'd0, 1'b1));
    // identity over five elements with walking values
    for (int k = 0; k < 5; k++) begin
      send_elem(elem(64'd1 << (k * 13), 64'd1 << (63 - k), ~(64'd1 << k), 64'd1 << (k * 7),
                     64'd3 << (k * 11), ~(64'd1 << (k * 15)), IDX_W'(k), IDX_W'(k),
                     k == 4));
    end

    // short random vectors, some with out-of-range entries
    while (sent < 20) send_run($urandom_range(1, 8), ($urandom_range(0, 2) == 0) ? 10 : 0);
    // a full vector with no gaps
    gaps_on = 1'b0;
    send_run(MAX_N, 0);
    gaps_on = 1'b1;
    // overflow: two extra items dropped, the last of them closes the run
    send_run(MAX_N + 2, 3);
    // more short vectors, the first stretch without gaps
    gaps_on = 1'b0;
    while (sent < 158) send_run($urandom_range(1, 8), ($urandom_range(0, 2) == 0) ? 10 : 0);
    gaps_on = 1'b1;
    while (sent < 164) send_run($urandom_range(1, 10), ($urandom_range(0, 2) == 0) ? 10 : 0);
    start <= 1'b0;

    // drain, then a short tail for any stray result
    guard = 0;
    while (sb.shuffled_q.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (sb.shuffled_q.size() != 0) begin
      $error("%0d predicted results never arrived", sb.shuffled_q.size());
      sb.failures++;
    end

    $display("%0d items in %0d vectors, %0d of them with a bad permutation entry",
             sent, sb.runs, sb.flagged_runs);
    $display("%0d results compared, including a full and an overflowing vector",
             sb.checked);
    if (sb.failures == 0) begin
      $display("masked_share_shuffle_top: match");
    end else begin
      $display("masked_share_shuffle_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/msshuf_pkg.sv
rtl/msshuf_ctrl.sv
rtl/msshuf_dpath.sv
rtl/masked_share_shuffle_top.sv
sim/masked_share_shuffle_top_test.sv
